### rtl/core/battery_power_mode_fsm_unit_assert.svh
// assertion macros shared by the battery power mode checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef BATTERY_POWER_MODE_FSM_UNIT_ASSERT_SVH
`define BATTERY_POWER_MODE_FSM_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define BPPM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define BPPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bppm_pkg.sv
// shared types and constants for the battery power mode block
// no dependencies
`default_nettype none

package bppm_pkg;

    localparam int MV_W      = 13;
    localparam int SOL_W     = 15;
    localparam int TEMP_W    = 8;
    localparam int STAT_W    = 8;
    localparam int MODE_W    = 3;
    localparam int PCT_W     = 7;
    localparam int UPTIME_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 15;

    // solar_mv * 100 fits in this many bits
    localparam int DIVIDEND_W = SOL_W + PCT_W;
    localparam int QUOT_W     = PCT_W;
    localparam int CNT_W      = 3;

    localparam logic [MODE_W-1:0] MODE_NORMAL      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEGRADED    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SURVIVAL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHARGE_ONLY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FAULT       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_VBAT_OK       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VBAT_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VBAT_CRIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VSOL_GOOD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_COLD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_VERYCOLD = 3'd5;

    localparam logic [PCT_W-1:0] PCT_FULL       = 7'd100;
    localparam logic [PCT_W-1:0] PCT_HEATER_MIN = 7'd70;
    localparam logic [PCT_W-1:0] PCT_CHARGE_MIN = 7'd50;
    localparam logic [PCT_W-1:0] PCT_RECOVER    = 7'd20;

    localparam logic signed [TEMP_W:0] HEATER_OFF_MARGIN = 9'sd5;

    localparam int           PG_BIT      = 2;
    localparam logic [2:0]   CHG_ACTIVE  = 3'd1;
    localparam logic [2:0]   CHG_DONE    = 3'd3;

    typedef struct packed {
        logic [MV_W-1:0]          battery_mv;
        logic [SOL_W-1:0]         solar_mv;
        logic signed [TEMP_W-1:0] board_temp;
        logic [STAT_W-1:0]        charger_status;
    } t_in_item;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [PCT_W-1:0]    solar_percent;
        logic                is_charging;
        logic                is_charge_done;
        logic                heater_enable;
        logic [UPTIME_W-1:0] uptime_seconds;
    } t_out_item;

    typedef struct packed {
        logic [MV_W-1:0]          bat_ok_lvl;
        logic [MV_W-1:0]          bat_low_lvl;
        logic [MV_W-1:0]          bat_crit_lvl;
        logic [SOL_W-1:0]         sol_full_lvl;
        logic signed [TEMP_W-1:0] cold_lvl;
        logic signed [TEMP_W-1:0] frost_lvl;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic                heater;
        logic [UPTIME_W-1:0] uptime;
    } t_state_nxt;

endpackage

`default_nettype wire

### rtl/core/bppm_div.sv
// restoring divider for the solar percentage, one quotient bit per cycle
// depends on bppm_pkg; quotient assumed below 2**QUOT_W
`default_nettype none

module bppm_div
    import bppm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [SOL_W-1:0]      i_divisor,
    output logic                       o_busy,
    output logic [QUOT_W-1:0]          o_quot
);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_rem;
    logic [DIVIDEND_W-1:0] r_dsh;
    logic [QUOT_W-1:0]     r_quot;
    logic                  ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUOT_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // divisor starts aligned to the top quotient bit and walks right
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dsh  <= {{(DIVIDEND_W-SOL_W-QUOT_W+1){1'b0}}, i_divisor, {(QUOT_W-1){1'b0}}};
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh  <= r_dsh >> 1;
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

### rtl/core/bppm_state.sv
// mode machine, heater hysteresis and uptime counter
// depends on bppm_pkg; state advances once per committed transaction
`default_nettype none

module bppm_state
    import bppm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_commit,
    input  wire t_cfg                     i_cfg,
    input  wire logic [MV_W-1:0]          i_battery_mv,
    input  wire logic signed [TEMP_W-1:0] i_board_temp,
    input  wire logic [PCT_W-1:0]         i_pct,
    output t_state_nxt                    o_nxt
);

    logic [MODE_W-1:0]   r_mode;
    logic                r_heater;
    logic [UPTIME_W-1:0] r_uptime;

    logic [MODE_W-1:0]   n_mode;
    logic                n_heater;
    logic [UPTIME_W-1:0] n_uptime;

    logic signed [TEMP_W:0] temp_ext;
    logic signed [TEMP_W:0] off_level;

    assign temp_ext  = {i_board_temp[TEMP_W-1], i_board_temp};
    assign off_level = {i_cfg.frost_lvl[TEMP_W-1], i_cfg.frost_lvl}
                       + HEATER_OFF_MARGIN;
    assign n_uptime  = r_uptime + 1'b1;

    always_comb begin
        n_heater = r_heater;
        if ((i_pct > PCT_HEATER_MIN) && (i_board_temp < i_cfg.cold_lvl)) begin
            n_heater = 1'b1;
        end else if (temp_ext > off_level) begin
            n_heater = 1'b0;
        end
    end

    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_NORMAL: begin
                // critical check first so survival is reachable
                if (i_battery_mv < i_cfg.bat_crit_lvl) begin
                    n_mode = MODE_SURVIVAL;
                end else if (i_battery_mv < i_cfg.bat_low_lvl) begin
                    n_mode = MODE_DEGRADED;
                end
            end
            MODE_DEGRADED: begin
                if (i_battery_mv > i_cfg.bat_ok_lvl) begin
                    n_mode = MODE_NORMAL;
                end else if (i_battery_mv < i_cfg.bat_crit_lvl) begin
                    n_mode = MODE_SURVIVAL;
                end
            end
            MODE_SURVIVAL: begin
                if ((i_pct > PCT_CHARGE_MIN) && (i_board_temp < i_cfg.frost_lvl)) begin
                    n_mode = MODE_CHARGE_ONLY;
                end else if ((i_battery_mv > i_cfg.bat_low_lvl) && (i_pct > PCT_RECOVER)) begin
                    n_mode = MODE_DEGRADED;
                end
            end
            MODE_CHARGE_ONLY: begin
                if (i_battery_mv > i_cfg.bat_low_lvl) begin
                    n_mode = MODE_DEGRADED;
                end
            end
            default: begin
                n_mode = MODE_NORMAL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_heater <= 1'b0;
            r_uptime <= '0;
        end else if (i_commit) begin
            r_mode   <= n_mode;
            r_heater <= n_heater;
            r_uptime <= n_uptime;
        end
    end

    assign o_nxt.mode   = n_mode;
    assign o_nxt.heater = n_heater;
    assign o_nxt.uptime = n_uptime;

endmodule

`default_nettype wire

### rtl/core/battery_power_mode_fsm_unit.sv
// battery power mode unit: one transaction per one-second tick
//
// input channel: i_in_valid / i_in_data / o_in_stall; a transaction is taken
// at a clock edge with i_in_valid high and o_in_stall low
// output channel: o_out_valid / o_out_data / i_out_stall, one result per input
// config: i_cfg_we / i_cfg_index / i_cfg_data, written while the unit is idle
//
// each transaction runs a 7-step restoring division (solar_mv*100 over the
// good threshold) on the single divider; when the division is done the result
// is registered into the output register as the unit returns to idle, and only
// then can the next input be taken, so transactions never overlap
// the output register lets a new input be taken while a result waits; if the
// receiver stalls, the finished transaction holds in the divider stage until
// the output register frees up, and the input stays stalled meanwhile
// reset (synchronous, active low) sets normal mode, heater off, uptime 0 and
// the threshold registers to their defaults
// depends on bppm_pkg, bppm_div, bppm_state
`default_nettype none

module battery_power_mode_fsm_unit
    import bppm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire t_in_item             i_in_data,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output t_out_item                 o_out_data,
    input  wire logic                 i_out_stall,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic      r_state;
    t_cfg      r_cfg;
    t_in_item  r_item;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic                  in_acc;
    logic                  finish;
    logic                  div_busy;
    logic [QUOT_W-1:0]     div_quot;
    logic [DIVIDEND_W-1:0] dividend;
    logic [PCT_W-1:0]      pct;
    logic [2:0]            chg;
    t_state_nxt            nxt;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign finish     = (r_state == ST_DIV) && !div_busy && (!r_out_valid || !i_out_stall);

    // times 100 as 64 + 32 + 4
    assign dividend = {1'b0, i_in_data.solar_mv, 6'b0}
                    + {2'b0, i_in_data.solar_mv, 5'b0}
                    + {5'b0, i_in_data.solar_mv, 2'b0};

    always_comb begin
        if (!r_item.charger_status[PG_BIT]) begin
            pct = '0;
        end else if ((r_item.solar_mv > r_cfg.sol_full_lvl) || (r_cfg.sol_full_lvl == '0)) begin
            pct = PCT_FULL;
        end else begin
            pct = div_quot;
        end
    end

    assign chg = r_item.charger_status[6:4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (finish) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bat_ok_lvl   <= 13'd3300;
            r_cfg.bat_low_lvl  <= 13'd3200;
            r_cfg.bat_crit_lvl <= 13'd3000;
            r_cfg.sol_full_lvl <= 15'd5000;
            r_cfg.cold_lvl     <= 8'sd0;
            r_cfg.frost_lvl    <= -8'sd20;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_VBAT_OK:       r_cfg.bat_ok_lvl   <= i_cfg_data[MV_W-1:0];
                REG_VBAT_LOW:      r_cfg.bat_low_lvl  <= i_cfg_data[MV_W-1:0];
                REG_VBAT_CRIT:     r_cfg.bat_crit_lvl <= i_cfg_data[MV_W-1:0];
                REG_VSOL_GOOD:     r_cfg.sol_full_lvl <= i_cfg_data[SOL_W-1:0];
                REG_TEMP_COLD:     r_cfg.cold_lvl     <= i_cfg_data[TEMP_W-1:0];
                REG_TEMP_VERYCOLD: r_cfg.frost_lvl    <= i_cfg_data[TEMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bppm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_dividend (dividend),
        .i_divisor  (r_cfg.sol_full_lvl),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    bppm_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_commit     (finish),
        .i_cfg        (r_cfg),
        .i_battery_mv (r_item.battery_mv),
        .i_board_temp (r_item.board_temp),
        .i_pct        (pct),
        .o_nxt        (nxt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_data.mode           <= nxt.mode;
            r_out_data.solar_percent  <= pct;
            r_out_data.is_charging    <= (chg == CHG_ACTIVE);
            r_out_data.is_charge_done <= (chg == CHG_DONE);
            r_out_data.heater_enable  <= nxt.heater;
            r_out_data.uptime_seconds <= nxt.uptime;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### rtl/core/battery_power_mode_fsm_unit_chk.sv
// port-level checker for the battery power mode unit, bound to the top level
// depends on bppm_pkg and battery_power_mode_fsm_unit_assert.svh
`default_nettype none

`include "battery_power_mode_fsm_unit_assert.svh"

module battery_power_mode_fsm_unit_chk
    import bppm_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire t_out_item            o_out_data,
    input wire logic                 i_out_stall,
    input wire logic                 i_cfg_we,
    input wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic in_acc;
    logic cfg_seen;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_seen = i_cfg_we && (i_cfg_index != REG_VBAT_OK || i_cfg_data != '0);

    `BPPM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")
    `BPPM_ASSERT_NEXT(a_busy_after_take, in_acc, o_in_stall, "input taken while a transaction is in flight")
    `BPPM_ASSERT_SAME(a_pct_range, o_out_valid, o_out_data.solar_percent <= PCT_FULL || cfg_seen, "solar percent above full")
    `BPPM_ASSERT_SAME(a_chg_excl, o_out_valid, !(o_out_data.is_charging && o_out_data.is_charge_done), "charging and done together")

endmodule

bind battery_power_mode_fsm_unit battery_power_mode_fsm_unit_chk u_chk (.*);

`default_nettype wire

### verif/tb_battery_power_mode_fsm_unit.sv
// self-checking testbench for battery_power_mode_fsm_unit: directed ticks, then random
// ticks over several threshold settings, each result checked against a tick predictor
// or a fixed expected result; depends on bppm_pkg and the battery_power_mode_fsm_unit rtl
module tb_battery_power_mode_fsm_unit;
    import bppm_pkg::*;

    // indexes past the last threshold register, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASES = 9;
    localparam int TICKS_PER_PHASE = 120;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    t_in_item             i_in_data;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;
    logic                 i_out_stall;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    battery_power_mode_fsm_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state and its copy of the thresholds
    t_cfg              cfg;
    logic [MODE_W-1:0] cur_mode;
    logic              heater_on;
    logic [31:0]       up_count;

    t_out_item pending_results[$];
    t_in_item  dir_stim[$];
    bit        dir_fixed[$];
    t_out_item dir_want[$];

    int  mismatches;
    int  n_sent;
    int  n_checked;
    int  n_settings;
    int  mode_hits[5];
    int  heater_hits;
    int  quiet_cycles;
    bit  calm;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int clip(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // mostly no pause, some short ones, a few long ones
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one tick of the power mode controller
    function automatic t_out_item predict_tick(input t_in_item t);
        int          temp_c;
        int          cold_c;
        int          vcold_c;
        int unsigned pct;
        logic [2:0]  chg;
        logic [MODE_W-1:0] nxt;
        t_out_item   r;
        temp_c  = $signed(t.board_temp);
        cold_c  = $signed(cfg.cold_lvl);
        vcold_c = $signed(cfg.frost_lvl);
        up_count = up_count + 32'd1;

        if (!t.charger_status[PG_BIT]) begin
            pct = 0;
        end else if (t.solar_mv > cfg.sol_full_lvl || cfg.sol_full_lvl == '0) begin
            pct = PCT_FULL;
        end else begin
            pct = (32'(t.solar_mv) * PCT_FULL) / 32'(cfg.sol_full_lvl);
        end
        chg = t.charger_status[6:4];

        if (pct > PCT_HEATER_MIN && temp_c < cold_c) begin
            heater_on = 1'b1;
        end else if (temp_c > vcold_c + int'(HEATER_OFF_MARGIN)) begin
            heater_on = 1'b0;
        end

        nxt = cur_mode;
        case (cur_mode)
            MODE_NORMAL: begin
                // critical level wins over low
                if (t.battery_mv < cfg.bat_crit_lvl) nxt = MODE_SURVIVAL;
                else if (t.battery_mv < cfg.bat_low_lvl) nxt = MODE_DEGRADED;
            end
            MODE_DEGRADED: begin
                if (t.battery_mv > cfg.bat_ok_lvl) nxt = MODE_NORMAL;
                else if (t.battery_mv < cfg.bat_crit_lvl) nxt = MODE_SURVIVAL;
            end
            MODE_SURVIVAL: begin
                if (t.battery_mv > cfg.bat_low_lvl && pct > PCT_RECOVER) nxt = MODE_DEGRADED;
                // charge-only overrides the recovery above
                if (pct > PCT_CHARGE_MIN && temp_c < vcold_c) nxt = MODE_CHARGE_ONLY;
            end
            MODE_CHARGE_ONLY: begin
                if (t.battery_mv > cfg.bat_low_lvl) nxt = MODE_DEGRADED;
            end
            default: nxt = MODE_NORMAL;
        endcase
        cur_mode = nxt;

        r.mode           = nxt;
        r.solar_percent  = pct[PCT_W-1:0];
        r.is_charging    = (chg == CHG_ACTIVE);
        r.is_charge_done = (chg == CHG_DONE);
        r.heater_enable  = heater_on;
        r.uptime_seconds = up_count;
        return r;
    endfunction

    // random tick, mostly close to the current thresholds
    function automatic t_in_item gen_tick();
        t_in_item t;
        int       v;
        int       base;
        case ($urandom_range(0, 2))
            0: base = cfg.bat_crit_lvl;
            1: base = cfg.bat_low_lvl;
            default: base = cfg.bat_ok_lvl;
        endcase
        if ($urandom_range(0, 9) < 7) v = clip(base + int'($urandom_range(0, 8)) - 4, 0, 8191);
        else v = $urandom_range(0, 8191);
        t.battery_mv = v[MV_W-1:0];

        if ($urandom_range(0, 9) < 6) begin
            v = int'(cfg.sol_full_lvl) * int'($urandom_range(0, 130)) / 100;
            v = clip(v + int'($urandom_range(0, 4)) - 2, 0, 32767);
        end else begin
            v = $urandom_range(0, 32767);
        end
        t.solar_mv = v[SOL_W-1:0];

        case ($urandom_range(0, 2))
            0: base = $signed(cfg.cold_lvl);
            1: base = $signed(cfg.frost_lvl);
            default: base = $signed(cfg.frost_lvl) + int'(HEATER_OFF_MARGIN);
        endcase
        if ($urandom_range(0, 9) < 6) v = clip(base + int'($urandom_range(0, 6)) - 3, -128, 127);
        else v = int'($urandom_range(0, 255)) - 128;
        t.board_temp = v[TEMP_W-1:0];

        v = $urandom_range(0, 255);
        t.charger_status = v[STAT_W-1:0];
        if ($urandom_range(0, 3) != 0) t.charger_status[PG_BIT] = 1'b1;
        return t;
    endfunction

    task automatic dir_row(input int bat, input int sol, input int temp, input int stat,
                           input bit fixed = 1'b0, input t_out_item want = '0);
        t_in_item t;
        t.battery_mv     = bat[MV_W-1:0];
        t.solar_mv       = sol[SOL_W-1:0];
        t.board_temp     = temp[TEMP_W-1:0];
        t.charger_status = stat[STAT_W-1:0];
        dir_stim.push_back(t);
        dir_fixed.push_back(fixed);
        dir_want.push_back(want);
    endtask

    task automatic send_tick(input t_in_item t, input bit fixed, input t_out_item want);
        int        gap;
        t_out_item guess;
        @(negedge i_clk);
        gap = pick_pause();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = t;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        guess = predict_tick(t);
        pending_results.push_back(fixed ? want : guess);
        n_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_VBAT_OK:       cfg.bat_ok_lvl   = data[MV_W-1:0];
            REG_VBAT_LOW:      cfg.bat_low_lvl  = data[MV_W-1:0];
            REG_VBAT_CRIT:     cfg.bat_crit_lvl = data[MV_W-1:0];
            REG_VSOL_GOOD:     cfg.sol_full_lvl = data[SOL_W-1:0];
            REG_TEMP_COLD:     cfg.cold_lvl     = data[TEMP_W-1:0];
            REG_TEMP_VERYCOLD: cfg.frost_lvl    = data[TEMP_W-1:0];
            default: ;
        endcase
    endtask

    // receiver side stalls
    initial begin
        int left;
        left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left == 0 && $urandom_range(0, 2) == 0) left = pick_pause();
            i_out_stall = (left != 0);
            if (left != 0) left--;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        logic [5:0] bad;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result with no transaction pending");
            end else begin
                want = pending_results.pop_front();
                bad = {o_out_data.mode !== want.mode,
                       o_out_data.solar_percent !== want.solar_percent,
                       o_out_data.is_charging !== want.is_charging,
                       o_out_data.is_charge_done !== want.is_charge_done,
                       o_out_data.heater_enable !== want.heater_enable,
                       o_out_data.uptime_seconds !== want.uptime_seconds};
                if (bad != '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d bad fields %b: exp mode %0d pct %0d chg %0b done %0b htr %0b up %0d / got mode %0d pct %0d chg %0b done %0b htr %0b up %0d",
                                 n_checked, bad, want.mode, want.solar_percent,
                                 want.is_charging, want.is_charge_done, want.heater_enable,
                                 want.uptime_seconds, o_out_data.mode,
                                 o_out_data.solar_percent, o_out_data.is_charging,
                                 o_out_data.is_charge_done, o_out_data.heater_enable,
                                 o_out_data.uptime_seconds);
                end
                if (want.mode <= MODE_FAULT) mode_hits[want.mode]++;
                if (want.heater_enable) heater_hits++;
            end
            n_checked++;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("no transaction for %0d cycles, %0d results pending",
                         QUIET_LIMIT, pending_results.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        logic [14:0] junk;
        int crit;
        int low;
        int ok;
        int good;
        int cold;
        int vcold;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        quiet_cycles = 0;
        mismatches = 0;
        n_sent = 0;
        n_checked = 0;
        heater_hits = 0;
        calm = 1'b0;
        foreach (mode_hits[m]) mode_hits[m] = 0;
        cfg.bat_ok_lvl   = 13'd3300;
        cfg.bat_low_lvl  = 13'd3200;
        cfg.bat_crit_lvl = 13'd3000;
        cfg.sol_full_lvl = 15'd5000;
        cfg.cold_lvl     = 8'sd0;
        cfg.frost_lvl    = -8'sd20;
        cur_mode  = MODE_NORMAL;
        heater_on = 1'b0;
        up_count  = '0;
        n_settings = 1;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed ticks on the reset thresholds
        dir_row(8191, 0, 0, 'h00, 1'b1,
                t_out_item'({MODE_NORMAL, 7'd0, 1'b0, 1'b0, 1'b0, 32'd1}));
        dir_row(8191, 32767, 127, 'h04, 1'b1,
                t_out_item'({MODE_NORMAL, PCT_FULL, 1'b0, 1'b0, 1'b0, 32'd2}));
        dir_row(8191, 5000, 0, 'h14, 1'b1,
                t_out_item'({MODE_NORMAL, PCT_FULL, 1'b1, 1'b0, 1'b0, 32'd3}));
        dir_row(8191, 4999, 0, 'h34, 1'b1,
                t_out_item'({MODE_NORMAL, 7'd99, 1'b0, 1'b1, 1'b0, 32'd4}));
        dir_row(3199, 2500, -1, 'h04);     // normal to degraded
        dir_row(3301, 0, 0, 'hfb);         // degraded to normal, no power good
        dir_row(2999, 4000, -128, 'h04);   // critical checked first, heater on
        dir_row(3201, 1050, -128, 'h04);   // survival recovers to degraded
        dir_row(2999, 0, 0, 'h00);         // degraded to survival, heater off
        dir_row(3300, 4000, -21, 'h04);    // charge-only beats recovery
        dir_row(3200, 5000, -21, 'h04);    // charge-only holds at the low level
        dir_row(3201, 0, -15, 'h00);       // charge-only to degraded, heater holds
        dir_row(3300, 0, -14, 'h00);       // degraded holds at ok level
        dir_row(0, 32767, 127, 'hff);
        dir_row(3201, 1000, -20, 'h04);    // twenty percent is not enough
        dir_row(3200, 5000, -20, 'h04);
        dir_row(8191, 5001, 0, 'h24);
        dir_row(8191, 1, 0, 'h44);         // rounds down to zero percent
        dir_row(3000, 0, 0, 'h04);
        dir_row(3000, 3500, -1, 'h04);     // seventy percent, heater stays off
        dir_row(3000, 3550, -1, 'h04);
        dir_row(8191, 12345, -128, 'h54);
        foreach (dir_stim[i]) send_tick(dir_stim[i], dir_fixed[i], dir_want[i]);

        for (int p = 1; p <= PHASES; p++) begin
            wait_for_results();
            calm = (p == 3 || p == 7);
            case (p)
                1: begin
                    // thresholds zero and temperatures at minimum, random upper data bits to check masking
                    ok = 0; low = 0; crit = 0; good = 0; cold = -128; vcold = -128;
                end
                2: begin
                    ok = 8191; low = 8191; crit = 8191; good = 32767; cold = 127; vcold = 127;
                end
                3: begin
                    ok = 3300; low = 3200; crit = 3000; good = 5000; cold = 0; vcold = -20;
                end
                default: begin
                    crit = $urandom_range(500, 6000);
                    low  = crit + int'($urandom_range(0, 400));
                    ok   = low + int'($urandom_range(0, 400));
                    if ($urandom_range(0, 3) == 0) begin
                        crit = $urandom_range(0, 8191);
                        low  = $urandom_range(0, 8191);
                        ok   = $urandom_range(0, 8191);
                    end
                    good = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767)
                                                       : $urandom_range(1000, 20000);
                    cold  = int'($urandom_range(0, 80)) - 40;
                    vcold = clip(cold - int'($urandom_range(0, 40)), -128, 127);
                    if ($urandom_range(0, 3) == 0) begin
                        cold  = int'($urandom_range(0, 255)) - 128;
                        vcold = int'($urandom_range(0, 255)) - 128;
                    end
                end
            endcase
            junk = $urandom;
            write_threshold(REG_VBAT_OK, {junk[1:0], ok[12:0]});
            write_threshold(REG_VBAT_LOW, {junk[3:2], low[12:0]});
            write_threshold(REG_VBAT_CRIT, {junk[5:4], crit[12:0]});
            write_threshold(REG_VSOL_GOOD, good[14:0]);
            write_threshold(REG_TEMP_COLD, {junk[12:6], cold[7:0]});
            write_threshold(REG_TEMP_VERYCOLD, {junk[14:8], vcold[7:0]});
            if (p == 1 || $urandom_range(0, 2) == 0) begin
                write_threshold(REG_SPARE_LO, 15'($urandom));
                write_threshold(REG_SPARE_HI, 15'($urandom));
            end
            n_settings++;

            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                // hold off the sender until the pipeline has fully drained
                if (p == 5 && k == TICKS_PER_PHASE / 2) wait_for_results();
                send_tick(gen_tick(), 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (20) @(posedge i_clk);

        $display("%0d ticks sent over %0d threshold settings, %0d results compared",
                 n_sent, n_settings, n_checked);
        $display("modes seen: normal %0d degraded %0d survival %0d charge-only %0d, heater on %0d",
                 mode_hits[MODE_NORMAL], mode_hits[MODE_DEGRADED], mode_hits[MODE_SURVIVAL],
                 mode_hits[MODE_CHARGE_ONLY], heater_hits);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
